>>> rtl/core/srk_pkg.sv
// ----------------------------------------------------------------------------
// srk_pkg
// Shared constants, types and codes for the smallest-range block.
// ----------------------------------------------------------------------------
package srk_pkg;

  localparam int MAX_LISTS  = 16;
  localparam int LIST_DEPTH = 64;

  localparam int LIST_W = $clog2(MAX_LISTS);
  localparam int IDX_W  = $clog2(LIST_DEPTH);
  localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_LISTS + 1);
  localparam int ADDR_W = LIST_W + IDX_W;
  localparam int MEM_DEPTH = MAX_LISTS * LIST_DEPTH;

  localparam int VAL_W  = 32;
  localparam int LN_W   = 4;
  localparam int CFG_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic OP_CODE_APPEND = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SORT_CHK,
    S_SORT_KEY,
    S_SORT_SHIFT,
    S_M_RD,
    S_M_UPD,
    S_M_DIFF,
    S_A_RD,
    S_A_CMP,
    S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_APPEND,
    OP_START,
    OP_NEXT_LIST,
    OP_KEY_RD,
    OP_KEY,
    OP_SHIFT,
    OP_PLACE,
    OP_M_RD,
    OP_M_UPD,
    OP_DIFF,
    OP_A_RD,
    OP_ADV,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic empty;
    logic ovf;
    logic key_done;
    logic shift;
    logic last;
    logic hit;
    logic exhaust;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/srk_if.sv
// ----------------------------------------------------------------------------
// srk_in_if / srk_out_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface srk_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [srk_pkg::LN_W-1:0]      list_number;
  logic signed [srk_pkg::VAL_W-1:0] value;

  modport source (output valid, operation, list_number, value, input ready);
  modport sink   (input valid, operation, list_number, value, output ready);
endinterface

interface srk_out_if;
  logic                        valid;
  logic                        ready;
  logic [srk_pkg::VAL_W-1:0]   min_range;
  logic [srk_pkg::STAT_W-1:0]  status;

  modport source (output valid, min_range, status, input ready);
  modport sink   (input valid, min_range, status, output ready);
endinterface

>>> rtl/core/srk_ram.sv
// ----------------------------------------------------------------------------
// srk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/srk_ctrl.sv
// ----------------------------------------------------------------------------
// srk_ctrl
// Sequencer for append, per-list insertion sort and the head merge.
// ----------------------------------------------------------------------------
module srk_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_operation_i,
  output logic                in_ready_o,
  input  srk_pkg::dp_status_t status_i,
  output srk_pkg::dp_op_e     op_o
);

  srk_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srk_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srk_pkg::S_IDLE: begin
        if (in_valid_i && in_operation_i != srk_pkg::OP_CODE_APPEND) begin
          state_d = srk_pkg::S_CHECK;
        end
      end
      srk_pkg::S_CHECK: begin
        state_d = (status_i.ovf || status_i.empty) ? srk_pkg::S_EMIT : srk_pkg::S_SORT_CHK;
      end
      srk_pkg::S_SORT_CHK: begin
        if (!status_i.key_done) begin
          state_d = srk_pkg::S_SORT_KEY;
        end else if (status_i.last) begin
          state_d = srk_pkg::S_M_RD;
        end
      end
      srk_pkg::S_SORT_KEY:   state_d = srk_pkg::S_SORT_SHIFT;
      srk_pkg::S_SORT_SHIFT: begin
        if (!status_i.shift) begin
          state_d = srk_pkg::S_SORT_CHK;
        end
      end
      srk_pkg::S_M_RD:  state_d = srk_pkg::S_M_UPD;
      srk_pkg::S_M_UPD: begin
        if (status_i.last) begin
          state_d = srk_pkg::S_M_DIFF;
        end else begin
          state_d = srk_pkg::S_M_RD;
        end
      end
      srk_pkg::S_M_DIFF: state_d = srk_pkg::S_A_RD;
      srk_pkg::S_A_RD:   state_d = srk_pkg::S_A_CMP;
      srk_pkg::S_A_CMP: begin
        if (status_i.hit && status_i.exhaust) begin
          state_d = srk_pkg::S_EMIT;
        end else if (status_i.last) begin
          state_d = srk_pkg::S_M_RD;
        end else begin
          state_d = srk_pkg::S_A_RD;
        end
      end
      srk_pkg::S_EMIT: begin
        if (status_i.out_free) begin
          state_d = srk_pkg::S_IDLE;
        end
      end
      default: state_d = srk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_o       = srk_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      srk_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_operation_i == srk_pkg::OP_CODE_APPEND) begin
          op_o = srk_pkg::OP_APPEND;
        end
      end
      srk_pkg::S_CHECK: begin
        if (!(status_i.ovf || status_i.empty)) begin
          op_o = srk_pkg::OP_START;
        end
      end
      srk_pkg::S_SORT_CHK: begin
        op_o = status_i.key_done ? srk_pkg::OP_NEXT_LIST : srk_pkg::OP_KEY_RD;
      end
      srk_pkg::S_SORT_KEY:   op_o = srk_pkg::OP_KEY;
      srk_pkg::S_SORT_SHIFT: op_o = status_i.shift ? srk_pkg::OP_SHIFT : srk_pkg::OP_PLACE;
      srk_pkg::S_M_RD:       op_o = srk_pkg::OP_M_RD;
      srk_pkg::S_M_UPD:      op_o = srk_pkg::OP_M_UPD;
      srk_pkg::S_M_DIFF:     op_o = srk_pkg::OP_DIFF;
      srk_pkg::S_A_RD:       op_o = srk_pkg::OP_A_RD;
      srk_pkg::S_A_CMP: begin
        if (!(status_i.hit && status_i.exhaust)) begin
          op_o = srk_pkg::OP_ADV;
        end
      end
      srk_pkg::S_EMIT: begin
        if (status_i.out_free) begin
          op_o = srk_pkg::OP_EMIT;
        end
      end
      default: op_o = srk_pkg::OP_NONE;
    endcase
  end

endmodule

>>> rtl/core/srk_dp.sv
// ----------------------------------------------------------------------------
// srk_dp
// Element store, list lengths, cursors, range tracking and result register.
// ----------------------------------------------------------------------------
module srk_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srk_pkg::dp_op_e                   op_i,
  output srk_pkg::dp_status_t               status_o,
  input  logic                              cfg_we_i,
  input  logic [srk_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [srk_pkg::LN_W-1:0]          list_number_i,
  input  logic signed [srk_pkg::VAL_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [srk_pkg::VAL_W-1:0]         min_range_o,
  output logic [srk_pkg::STAT_W-1:0]        status_code_o
);

  localparam int LIST_W = srk_pkg::LIST_W;
  localparam int IDX_W  = srk_pkg::IDX_W;
  localparam int LEN_W  = srk_pkg::LEN_W;
  localparam int CNT_W  = srk_pkg::CNT_W;
  localparam int VAL_W  = srk_pkg::VAL_W;

  logic [srk_pkg::CFG_W-1:0] count_q;
  logic [LEN_W-1:0]          len_q [srk_pkg::MAX_LISTS];
  logic [IDX_W-1:0]          cur_q [srk_pkg::MAX_LISTS];
  logic [CNT_W-1:0]          li_q;
  logic [LEN_W-1:0]          i_q;
  logic [IDX_W-1:0]          j_q;
  logic signed [VAL_W-1:0]   key_q, lo_q, hi_q;
  logic [VAL_W:0]            best_q;
  logic                      ovf_q;
  logic                      out_valid_q;
  logic [VAL_W-1:0]          out_range_q;
  logic [srk_pkg::STAT_W-1:0] out_code_q;

  logic [CNT_W-1:0]          n_eff;
  logic [LIST_W-1:0]         li_idx, ln_idx, len_idx;
  logic                      ln_ok;
  logic [LEN_W-1:0]          len_sel;
  logic [IDX_W-1:0]          cur_sel;
  logic                      empty;
  logic signed [VAL_W-1:0]   rdata_s;
  logic [VAL_W-1:0]          rdata;
  logic                      ram_we;
  logic [srk_pkg::ADDR_W-1:0] waddr, raddr;
  logic [VAL_W-1:0]          wdata;
  logic [VAL_W:0]            diff;
  logic                      last;

  always_comb begin
    if (count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(count_q) > srk_pkg::MAX_LISTS) begin
      n_eff = CNT_W'(srk_pkg::MAX_LISTS);
    end else begin
      n_eff = CNT_W'(count_q);
    end
  end

  assign li_idx  = li_q[LIST_W-1:0];
  assign ln_idx  = LIST_W'(list_number_i);
  assign ln_ok   = 32'(list_number_i) < srk_pkg::MAX_LISTS;
  assign len_idx = (op_i == srk_pkg::OP_APPEND) ? ln_idx : li_idx;
  assign len_sel = len_q[len_idx];
  assign cur_sel = cur_q[li_idx];
  assign rdata_s = $signed(rdata);
  assign last    = li_q == n_eff - CNT_W'(1);
  assign diff    = {hi_q[VAL_W-1], hi_q} - {lo_q[VAL_W-1], lo_q};

  always_comb begin
    empty = 1'b0;
    for (int k = 0; k < srk_pkg::MAX_LISTS; k++) begin
      if (k < 32'(n_eff) && len_q[k] == '0) begin
        empty = 1'b1;
      end
    end
  end

  // memory address and write selection
  always_comb begin
    ram_we = 1'b0;
    waddr  = {li_idx, j_q};
    wdata  = rdata;
    raddr  = {li_idx, cur_sel};
    case (op_i)
      srk_pkg::OP_APPEND: begin
        ram_we = ln_ok && len_sel != LEN_W'(srk_pkg::LIST_DEPTH);
        waddr  = {ln_idx, len_sel[IDX_W-1:0]};
        wdata  = value_i;
      end
      srk_pkg::OP_KEY_RD: raddr = {li_idx, i_q[IDX_W-1:0]};
      srk_pkg::OP_KEY:    raddr = {li_idx, i_q[IDX_W-1:0] - IDX_W'(1)};
      srk_pkg::OP_SHIFT: begin
        ram_we = 1'b1;
        raddr  = {li_idx, j_q - IDX_W'(2)};
      end
      srk_pkg::OP_PLACE: begin
        ram_we = 1'b1;
        wdata  = key_q;
      end
      default: ;
    endcase
  end

  srk_ram #(
    .WIDTH (VAL_W),
    .DEPTH (srk_pkg::MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= srk_pkg::CFG_W'(1);
      li_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      best_q      <= '1;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < srk_pkg::MAX_LISTS; k++) begin
        len_q[k] <= '0;
        cur_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        srk_pkg::OP_APPEND: begin
          if (ln_ok) begin
            if (len_sel == LEN_W'(srk_pkg::LIST_DEPTH)) begin
              ovf_q <= 1'b1;
            end else begin
              len_q[ln_idx] <= len_sel + LEN_W'(1);
            end
          end
        end
        srk_pkg::OP_START: begin
          li_q <= '0;
          i_q  <= LEN_W'(1);
        end
        srk_pkg::OP_NEXT_LIST: begin
          li_q <= last ? '0 : li_q + CNT_W'(1);
          i_q  <= LEN_W'(1);
        end
        srk_pkg::OP_KEY: j_q <= i_q[IDX_W-1:0];
        srk_pkg::OP_SHIFT: j_q <= j_q - IDX_W'(1);
        srk_pkg::OP_PLACE: i_q <= i_q + LEN_W'(1);
        srk_pkg::OP_M_UPD: li_q <= li_q + CNT_W'(1);
        srk_pkg::OP_DIFF: begin
          li_q <= '0;
          if (diff < best_q) begin
            best_q <= diff;
          end
        end
        srk_pkg::OP_ADV: begin
          if (rdata_s == lo_q) begin
            cur_q[li_idx] <= cur_sel + IDX_W'(1);
          end
          li_q <= last ? '0 : li_q + CNT_W'(1);
        end
        srk_pkg::OP_EMIT: begin
          out_valid_q <= 1'b1;
          best_q      <= '1;
          ovf_q       <= 1'b0;
          for (int k = 0; k < srk_pkg::MAX_LISTS; k++) begin
            len_q[k] <= '0;
            cur_q[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (op_i == srk_pkg::OP_KEY) begin
      key_q <= rdata_s;
    end
    if (op_i == srk_pkg::OP_M_UPD) begin
      if (li_q == '0 || rdata_s < lo_q) begin
        lo_q <= rdata_s;
      end
      if (li_q == '0 || rdata_s > hi_q) begin
        hi_q <= rdata_s;
      end
    end
    if (op_i == srk_pkg::OP_EMIT) begin
      if (ovf_q) begin
        out_code_q  <= srk_pkg::ST_OVERFLOW;
        out_range_q <= '0;
      end else if (empty) begin
        out_code_q  <= srk_pkg::ST_EMPTY;
        out_range_q <= '0;
      end else begin
        out_code_q  <= srk_pkg::ST_OK;
        out_range_q <= best_q[VAL_W-1:0];
      end
    end
  end

  assign status_o.empty    = empty;
  assign status_o.ovf      = ovf_q;
  assign status_o.key_done = i_q >= len_sel;
  assign status_o.shift    = (j_q != '0) && (rdata_s > key_q);
  assign status_o.last     = last;
  assign status_o.hit      = rdata_s == lo_q;
  assign status_o.exhaust  = (LEN_W'(cur_sel) + LEN_W'(1)) >= len_sel;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign min_range_o   = out_range_q;
  assign status_code_o = out_code_q;

`ifndef NO_ASSERTIONS
  a_ok_has_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == srk_pkg::OP_EMIT && !ovf_q && !empty) |-> !best_q[VAL_W])
    else $error("ok result without a measured range");
  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == srk_pkg::OP_EMIT) |=> (!ovf_q && best_q == '1))
    else $error("state not cleared after result");
  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == srk_pkg::OP_SHIFT) |-> (j_q != '0))
    else $error("sort shift below list head");
  a_list_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == srk_pkg::OP_M_RD || op_i == srk_pkg::OP_A_RD) |-> (li_q < n_eff))
    else $error("merge visits a list not in use");
`endif

endmodule

>>> rtl/core/smallest_range_k_sorted_lists.sv
// ----------------------------------------------------------------------------
// smallest_range_k_sorted_lists
// Smallest range covering one element of each of up to 16 sorted lists.
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// in_i      in   valid/ready      operation, list_number, value
// out_o     out  valid/ready      min_range, status
// cfg       in   cfg_we_i         cfg_data_i (list_count)
//
// appends stream at one per cycle while no finish is in progress
// a finish runs an insertion sort per list on the element ram (one write port
// and one read port), then a merge in rounds, one round per advance of the
// minimum heads
// reset clears lengths, cursors and flags at once; the ram needs no clearing
// input is held off during a finish; a pending result only stalls the next one
// ----------------------------------------------------------------------------
module smallest_range_k_sorted_lists (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  srk_in_if.sink                     in_i,
  srk_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [srk_pkg::CFG_W-1:0]  cfg_data_i
);

  srk_pkg::dp_op_e     op;
  srk_pkg::dp_status_t status;

  srk_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_operation_i (in_i.operation),
    .in_ready_o     (in_i.ready),
    .status_i       (status),
    .op_o           (op)
  );

  srk_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .list_number_i (in_i.list_number),
    .value_i       (in_i.value),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .min_range_o   (out_o.min_range),
    .status_code_o (out_o.status)
  );

endmodule
